### design/pmf_pkg.sv
// ---------------------------------------------------------------------------
// pmf_pkg
// Shared constants and types for the pose median filter with mount rotation.
// ---------------------------------------------------------------------------
`default_nettype none

package pmf_pkg;

    localparam int WINDOW_DEF      = 7;
    localparam int SAMPLE_BITS_DEF = 20;

    localparam int NUM_POSE   = 6;
    localparam int COEF_W     = 15;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int                 DROP_MARKER_RST = -1024;
    localparam logic [COEF_W-1:0]  MOUNT_COS_RST   = 15'd28378;
    localparam logic [COEF_W-1:0]  MOUNT_SIN_RST   = 15'd16384;

    // pose channel order inside the lane array
    localparam int CH_POS_X = 0;
    localparam int CH_POS_Y = 1;
    localparam int CH_POS_Z = 2;
    localparam int CH_ANG_X = 3;
    localparam int CH_ANG_Y = 4;
    localparam int CH_ANG_Z = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DROP_MARKER = 2'd0,
        REG_MOUNT_COS   = 2'd1,
        REG_MOUNT_SIN   = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

### design/pose_median_filter_rotate.sv
// ---------------------------------------------------------------------------
// pose_median_filter_rotate
// Per-channel sliding median of camera pose and heading, with drop detection
// and rotation of the linear medians into the body frame.
// ---------------------------------------------------------------------------
// Usage:
//   Frame channel: frame_valid / frame_stall with pos_*, ang_*, heading_in.
//   A request is taken at a rising edge with frame_valid high and frame_stall
//   low. Result channel: result_valid / result_stall with the body pose,
//   angle medians, heading median, drop count and frame_dropped flag.
//   Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
//   drop marker (0), mount cosine (1) or mount sine (2); write while idle.
//   One request per cycle is sustained while no result waits on result_stall.
//   Seven median lanes (six pose, one heading) run in parallel, each ranking
//   its whole window combinationally; the rotation takes two stages
//   (products, then sum/round/saturate).
//   While result_stall holds a pending result, the whole pipeline freezes
//   and frame_stall rises in the same cycle.
//   Reset clears all windows, held medians, slots and the drop count, and
//   loads the register reset values; there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module pose_median_filter_rotate #(
    parameter int WINDOW      = pmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = pmf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             frame_valid,
    output logic                                  frame_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]    pos_x,
    input  wire logic signed [SAMPLE_BITS-1:0]    pos_y,
    input  wire logic signed [SAMPLE_BITS-1:0]    pos_z,
    input  wire logic signed [SAMPLE_BITS-1:0]    ang_x,
    input  wire logic signed [SAMPLE_BITS-1:0]    ang_y,
    input  wire logic signed [SAMPLE_BITS-1:0]    ang_z,
    input  wire logic signed [SAMPLE_BITS-1:0]    heading_in,

    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic signed [SAMPLE_BITS-1:0]         body_x,
    output logic signed [SAMPLE_BITS-1:0]         body_y,
    output logic signed [SAMPLE_BITS-1:0]         body_z,
    output logic signed [SAMPLE_BITS-1:0]         med_ang_x,
    output logic signed [SAMPLE_BITS-1:0]         med_ang_y,
    output logic signed [SAMPLE_BITS-1:0]         med_ang_z,
    output logic signed [SAMPLE_BITS-1:0]         heading_out,
    output logic [pmf_pkg::COUNT_W-1:0]           drop_count,
    output logic                                  frame_dropped,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import pmf_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    // configuration
    logic signed [SAMPLE_BITS-1:0] drop_marker_reg;
    logic [COEF_W-1:0]             mount_cos_reg;
    logic [COEF_W-1:0]             mount_sin_reg;

    // pipeline control
    logic advance;
    logic accept;
    logic drop_now;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_drop_reg, s2_drop_reg, s3_drop_reg, out_drop_reg;

    logic [SLOT_W-1:0] pose_slot_reg, pose_slot_next;
    logic [SLOT_W-1:0] head_slot_reg, head_slot_next;
    logic [COUNT_W-1:0] tally_reg, tally_next;

    logic signed [SAMPLE_BITS-1:0] pose_in  [NUM_POSE];
    logic signed [SAMPLE_BITS-1:0] pose_med [NUM_POSE];
    logic signed [SAMPLE_BITS-1:0] head_med;

    // sideband carried alongside the rotation stages
    logic signed [SAMPLE_BITS-1:0] s3_ang_x_reg, s3_ang_y_reg, s3_ang_z_reg, s3_head_reg;
    logic [COUNT_W-1:0]            s3_count_reg;
    logic signed [SAMPLE_BITS-1:0] out_ang_x_reg, out_ang_y_reg, out_ang_z_reg, out_head_reg;
    logic [COUNT_W-1:0]            out_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_marker_reg <= SAMPLE_BITS'(DROP_MARKER_RST);
            mount_cos_reg   <= MOUNT_COS_RST;
            mount_sin_reg   <= MOUNT_SIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DROP_MARKER: drop_marker_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_MOUNT_COS:   mount_cos_reg   <= cfg_data[COEF_W-1:0];
                REG_MOUNT_SIN:   mount_sin_reg   <= cfg_data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    // freeze everything while a finished result waits
    assign advance     = !(out_valid_reg && result_stall);
    assign frame_stall = !advance;
    assign accept      = frame_valid && advance;
    assign drop_now    = (pos_z == drop_marker_reg);

    assign pose_slot_next = (pose_slot_reg == SLOT_LAST) ? '0 : pose_slot_reg + 1'b1;
    assign head_slot_next = (head_slot_reg == SLOT_LAST) ? '0 : head_slot_reg + 1'b1;
    assign tally_next     = (tally_reg == '1) ? tally_reg : tally_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_slot_reg <= '0;
            head_slot_reg <= '0;
        end
        else if (accept)
        begin
            head_slot_reg <= head_slot_next;
            if (!drop_now)
            begin
                pose_slot_reg <= pose_slot_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_drop_reg   <= 1'b0;
            s2_drop_reg   <= 1'b0;
            s3_drop_reg   <= 1'b0;
            out_drop_reg  <= 1'b0;
            tally_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= frame_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            s1_drop_reg   <= drop_now;
            s2_drop_reg   <= s1_drop_reg;
            s3_drop_reg   <= s2_drop_reg;
            out_drop_reg  <= s3_drop_reg;
            if (s1_valid_reg && s1_drop_reg)
            begin
                tally_reg <= tally_next;
            end
        end
    end

    assign pose_in[CH_POS_X] = pos_x;
    assign pose_in[CH_POS_Y] = pos_y;
    assign pose_in[CH_POS_Z] = pos_z;
    assign pose_in[CH_ANG_X] = ang_x;
    assign pose_in[CH_ANG_Y] = ang_y;
    assign pose_in[CH_ANG_Z] = ang_z;

    for (genvar c = 0; c < NUM_POSE; c++)
    begin : g_pose_lane
        pmf_lane #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (accept && !drop_now),
            .wr_slot (pose_slot_reg),
            .wr_data (pose_in[c]),
            .load    (advance && s1_valid_reg && !s1_drop_reg),
            .median  (pose_med[c])
        );
    end

    pmf_lane #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_head_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_slot (head_slot_reg),
        .wr_data (heading_in),
        .load    (advance && s1_valid_reg),
        .median  (head_med)
    );

    pmf_rotate #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .mx        (pose_med[CH_POS_X]),
        .my        (pose_med[CH_POS_Y]),
        .mz        (pose_med[CH_POS_Z]),
        .mount_cos (mount_cos_reg),
        .mount_sin (mount_sin_reg),
        .body_x    (body_x),
        .body_y    (body_y),
        .body_z    (body_z)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_ang_x_reg  <= pose_med[CH_ANG_X];
            s3_ang_y_reg  <= pose_med[CH_ANG_Y];
            s3_ang_z_reg  <= pose_med[CH_ANG_Z];
            s3_head_reg   <= head_med;
            s3_count_reg  <= tally_reg;
            out_ang_x_reg <= s3_ang_x_reg;
            out_ang_y_reg <= s3_ang_y_reg;
            out_ang_z_reg <= s3_ang_z_reg;
            out_head_reg  <= s3_head_reg;
            out_count_reg <= s3_count_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign med_ang_x     = out_ang_x_reg;
    assign med_ang_y     = out_ang_y_reg;
    assign med_ang_z     = out_ang_z_reg;
    assign heading_out   = out_head_reg;
    assign drop_count    = out_count_reg;
    assign frame_dropped = out_drop_reg;

endmodule

`default_nettype wire

### design/pmf_lane.sv
// ---------------------------------------------------------------------------
// pmf_lane
// One sliding window with a rank-based median finder and a held median.
// ---------------------------------------------------------------------------
`default_nettype none

module pmf_lane #(
    parameter int WINDOW      = 7,
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(WINDOW)-1:0]     wr_slot,
    input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
    input  wire logic                          load,
    output logic signed [SAMPLE_BITS-1:0]      median
);

    localparam int MID = WINDOW / 2;

    logic signed [SAMPLE_BITS-1:0] win_reg [WINDOW];
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic signed [SAMPLE_BITS-1:0] median_next;
    logic [WINDOW-1:0]             below [WINDOW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            win_reg[wr_slot] <= wr_data;
        end
    end

    // Rank each entry; equal values are ordered by position so ranks are unique.
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                below[i][j] = (win_reg[j] < win_reg[i]) ||
                              ((j < i) && (win_reg[j] == win_reg[i]));
            end
        end
        for (int i = 0; i < WINDOW; i++)
        begin
            if ($countones(below[i]) == MID)
            begin
                median_next = win_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg <= '0;
        end
        else if (load)
        begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

`default_nettype wire

### design/pmf_rotate.sv
// ---------------------------------------------------------------------------
// pmf_rotate
// Rotate held linear medians by the mount angle: registered products, then
// sum, round half up and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module pmf_rotate #(
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic signed [SAMPLE_BITS-1:0]   mx,
    input  wire logic signed [SAMPLE_BITS-1:0]   my,
    input  wire logic signed [SAMPLE_BITS-1:0]   mz,
    input  wire logic [pmf_pkg::COEF_W-1:0]      mount_cos,
    input  wire logic [pmf_pkg::COEF_W-1:0]      mount_sin,
    output logic signed [SAMPLE_BITS-1:0]        body_x,
    output logic signed [SAMPLE_BITS-1:0]        body_y,
    output logic signed [SAMPLE_BITS-1:0]        body_z
);

    import pmf_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]       HALF = SUM_W'(2 ** (COEF_W - 1));

    logic signed [COEF_W:0]        cos_s;
    logic signed [COEF_W:0]        sin_s;
    logic signed [PROD_W-1:0]      cz_reg, sx_reg, sz_reg, cx_reg;
    logic signed [SAMPLE_BITS-1:0] my_reg;
    logic signed [SUM_W-1:0]       sum_x, sum_z, shr_x, shr_z;
    logic signed [SAMPLE_BITS-1:0] bx_next, by_next, bz_next;
    logic signed [SAMPLE_BITS-1:0] bx_reg, by_reg, bz_reg;

    assign cos_s = {1'b0, mount_cos};
    assign sin_s = {1'b0, mount_sin};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cz_reg <= cos_s * mz;
            sx_reg <= sin_s * mx;
            sz_reg <= sin_s * mz;
            cx_reg <= cos_s * mx;
            my_reg <= my;
        end
    end

    always_comb
    begin
        sum_x = SUM_W'(cz_reg) + SUM_W'(sx_reg) + HALF;
        sum_z = SUM_W'(sz_reg) - SUM_W'(cx_reg) + HALF;
        shr_x = sum_x >>> COEF_W;
        shr_z = sum_z >>> COEF_W;

        if (shr_x > SMAX)
            bx_next = SMAX;
        else if (shr_x < SMIN)
            bx_next = SMIN;
        else
            bx_next = shr_x[SAMPLE_BITS-1:0];

        if (shr_z > SMAX)
            bz_next = SMAX;
        else if (shr_z < SMIN)
            bz_next = SMIN;
        else
            bz_next = shr_z[SAMPLE_BITS-1:0];

        // negating the most negative value clamps to the maximum
        by_next = (my_reg == SMIN) ? SMAX : -my_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg <= '0;
            by_reg <= '0;
            bz_reg <= '0;
        end
        else if (advance)
        begin
            bx_reg <= bx_next;
            by_reg <= by_next;
            bz_reg <= bz_next;
        end
    end

    assign body_x = bx_reg;
    assign body_y = by_reg;
    assign body_z = bz_reg;

endmodule

`default_nettype wire
